// File: hw/rtl/ncr_pkg.sv
// Shared constants, types and divider tables for the NED to ECEF rotation block
`default_nettype none

package ncr_pkg;

    // vector and trig formats
    localparam int VEC_WIDTH      = 16;
    localparam int TRIG_FRAC_BITS = 15;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
    localparam int VEC_MAX        = 2 ** (VEC_WIDTH - 1) - 1;

    // angles in 1/256 degree
    localparam int LAT_W         = 16;
    localparam int LON_W         = 17;
    localparam int ANG_W         = 17;
    localparam int R_W           = 15;
    localparam int RF_W          = 14;
    localparam int ANG_FULL      = 92160;
    localparam int ANG_3QUARTER  = 69120;
    localparam int ANG_HALF      = 46080;
    localparam int ANG_QUARTER   = 23040;
    localparam int ANG_EIGHTH    = 11520;

    // folded angle to Q30 radians: x = r*X_INT_MUL + floor((r*X_FRAC_MUL + bias) / 23040)
    localparam int X_W           = 30;
    localparam int X_INT_MUL     = 73204;
    localparam int X_FRAC_MUL    = 9553;
    localparam int X_FRAC_BIAS   = 11520;
    localparam int XF_W          = 27;
    localparam int X_DIV_SHIFT   = 9;
    localparam int XN_W          = XF_W - X_DIV_SHIFT;
    localparam int X_DIV         = 45;
    localparam int X_RECIP       = 372827;
    localparam int X_RECIP_SHIFT = 24;
    localparam int XR_W          = 19;
    localparam int XQ_W          = 13;

    // series terms, Q30 values
    localparam int T_W        = 31;
    localparam int NUM_TERMS  = 6;
    localparam int SIN_TERMS  = 5;
    localparam int RECIP_W    = 32;
    localparam int RND_SH     = 30 - TRIG_FRAC_BITS;
    localparam logic [T_W-1:0] ONE_Q30 = T_W'(32'h4000_0000);

    // factorial steps and floor(2^32 / step); the last sine entry is never used
    localparam logic [7:0] SIN_DIV [NUM_TERMS] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd1};
    localparam logic [7:0] COS_DIV [NUM_TERMS] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
    localparam logic [RECIP_W-1:0] SIN_RECIP [NUM_TERMS] = '{
        32'd715827882, 32'd214748364, 32'd102261126,
        32'd59652323,  32'd39045157,  32'hFFFF_FFFF};
    localparam logic [RECIP_W-1:0] COS_RECIP [NUM_TERMS] = '{
        32'd2147483648, 32'd357913941, 32'd143165576,
        32'd76695844,   32'd47721858,  32'd32537631};

    // pipeline depths
    localparam int SC_LAT  = 5 + 3 * NUM_TERMS + 1;
    localparam int ROT_LAT = 6;

    // rotation widths
    localparam int PROD_W = 2 * TRIG_W;
    localparam int ROW_W  = TRIG_W + VEC_WIDTH;
    localparam int SUM_W  = ROW_W + 2;
    localparam int MAG_W  = SUM_W - TRIG_FRAC_BITS;

    typedef logic signed [TRIG_W-1:0]    trig_t;
    typedef logic signed [VEC_WIDTH-1:0] vec_t;
    typedef logic [ANG_W-1:0]            ang_t;

    typedef struct packed {
        logic valid;
        logic pole;
    } ctl_t;

    typedef struct packed {
        vec_t n;
        vec_t e;
        vec_t d;
    } vec3_t;

endpackage

`default_nettype wire

// File: hw/rtl/ncr_sincos.sv
// Pipelined sine/cosine of an angle in 1/256 degree, Q(TRIG_FRAC_BITS) results
`default_nettype none

module ncr_sincos
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire ncr_pkg::ctl_t ctl_in,
    input  wire ncr_pkg::ang_t angle,
    output ncr_pkg::ctl_t      ctl_out,
    output ncr_pkg::trig_t     sin_val,
    output ncr_pkg::trig_t     cos_val
);
    import ncr_pkg::*;

    typedef struct packed {
        ctl_t           ctl;
        logic [1:0]     q;
        logic           swap;
        logic [X_W-1:0] x2;
        logic [T_W-1:0] ts;
        logic [T_W-1:0] tc;
        logic [T_W-1:0] sn;
        logic [T_W-1:0] cs;
    } trm_t;

    // stage A: quadrant and octant fold
    ctl_t            a_ctl_reg;
    logic [1:0]      a_q_reg;
    logic            a_swap_reg;
    logic [RF_W-1:0] a_rf_reg;
    logic [1:0]      a_q_next;
    logic [ANG_W-1:0] r_full;
    logic [R_W-1:0]  r_part;
    logic            a_swap_next;
    logic [RF_W-1:0] a_rf_next;

    always_comb
    begin
        if (angle >= ANG_W'(ANG_3QUARTER))
        begin
            a_q_next = 2'd3;
            r_full   = angle - ANG_W'(ANG_3QUARTER);
        end
        else if (angle >= ANG_W'(ANG_HALF))
        begin
            a_q_next = 2'd2;
            r_full   = angle - ANG_W'(ANG_HALF);
        end
        else if (angle >= ANG_W'(ANG_QUARTER))
        begin
            a_q_next = 2'd1;
            r_full   = angle - ANG_W'(ANG_QUARTER);
        end
        else
        begin
            a_q_next = 2'd0;
            r_full   = angle;
        end
        r_part      = r_full[R_W-1:0];
        a_swap_next = r_part > R_W'(ANG_EIGHTH);
        a_rf_next   = a_swap_next ? RF_W'(R_W'(ANG_QUARTER) - r_part) : r_part[RF_W-1:0];
    end

    // stage B: integer part and scaled fraction of the radian conversion
    ctl_t            b_ctl_reg;
    logic [1:0]      b_q_reg;
    logic            b_swap_reg;
    logic [XN_W-1:0] b_n_reg;
    logic [X_W-1:0]  b_base_reg;
    logic [XF_W-1:0] frac_sum;

    assign frac_sum = XF_W'(a_rf_reg) * XF_W'(X_FRAC_MUL) + XF_W'(X_FRAC_BIAS);

    // stage C: divide by 45 via reciprocal, may be one short
    ctl_t                   c_ctl_reg;
    logic [1:0]             c_q_reg;
    logic                   c_swap_reg;
    logic [XN_W-1:0]        c_n_reg;
    logic [X_W-1:0]         c_base_reg;
    logic [XQ_W-1:0]        c_q0_reg;
    logic [XN_W+XR_W-1:0]   n_recip;

    assign n_recip = (XN_W+XR_W)'(b_n_reg) * (XN_W+XR_W)'(X_RECIP);

    // stage D: correction, x in Q30
    ctl_t           d_ctl_reg;
    logic [1:0]     d_q_reg;
    logic           d_swap_reg;
    logic [X_W-1:0] d_x_reg;
    logic [XN_W-1:0] x_rem;
    logic [X_W-1:0] d_x_next;

    assign x_rem    = c_n_reg - XN_W'(c_q0_reg) * XN_W'(X_DIV);
    assign d_x_next = c_base_reg + X_W'(c_q0_reg) + X_W'(x_rem >= XN_W'(X_DIV));

    // stage E: x squared, series seeds
    trm_t             e_reg;
    trm_t             e_next;
    logic [2*X_W-1:0] xx;
    logic [2*X_W-1:0] xx_rnd;

    assign xx     = (2*X_W)'(d_x_reg) * (2*X_W)'(d_x_reg);
    assign xx_rnd = xx + (2*X_W)'(ONE_Q30 >> 1);

    always_comb
    begin
        e_next.ctl  = d_ctl_reg;
        e_next.q    = d_q_reg;
        e_next.swap = d_swap_reg;
        e_next.x2   = xx_rnd[2*X_W-1:X_W];
        e_next.ts   = T_W'(d_x_reg);
        e_next.tc   = ONE_Q30;
        e_next.sn   = T_W'(d_x_reg);
        e_next.cs   = ONE_Q30;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
            b_ctl_reg <= '0;
            c_ctl_reg <= '0;
            d_ctl_reg <= '0;
            e_reg     <= '0;
        end
        else if (en)
        begin
            a_ctl_reg <= ctl_in;
            b_ctl_reg <= a_ctl_reg;
            c_ctl_reg <= b_ctl_reg;
            d_ctl_reg <= c_ctl_reg;
            e_reg     <= e_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_q_reg    <= a_q_next;
            a_swap_reg <= a_swap_next;
            a_rf_reg   <= a_rf_next;
            b_q_reg    <= a_q_reg;
            b_swap_reg <= a_swap_reg;
            b_n_reg    <= frac_sum[XF_W-1:X_DIV_SHIFT];
            b_base_reg <= X_W'(a_rf_reg) * X_W'(X_INT_MUL);
            c_q_reg    <= b_q_reg;
            c_swap_reg <= b_swap_reg;
            c_n_reg    <= b_n_reg;
            c_base_reg <= b_base_reg;
            c_q0_reg   <= n_recip[XN_W+XR_W-1:X_RECIP_SHIFT];
            d_q_reg    <= c_q_reg;
            d_swap_reg <= c_swap_reg;
            d_x_reg    <= d_x_next;
        end
    end

    // series terms: multiply by x^2, divide by the factorial step, accumulate
    trm_t tb [NUM_TERMS+1];
    assign tb[0] = e_reg;

    for (genvar j = 0; j < NUM_TERMS; j++)
    begin : g_term
        trm_t                   m_reg;
        logic [T_W-1:0]         m_ps_reg;
        logic [T_W-1:0]         m_pc_reg;
        trm_t                   r_reg;
        logic [T_W-1:0]         r_ps_reg;
        logic [T_W-1:0]         r_pc_reg;
        logic [T_W-1:0]         r_qs_reg;
        logic [T_W-1:0]         r_qc_reg;
        trm_t                   s_reg;
        trm_t                   s_next;
        logic [T_W+X_W-1:0]     ps_full;
        logic [T_W+X_W-1:0]     pc_full;
        logic [T_W+RECIP_W-1:0] qs_full;
        logic [T_W+RECIP_W-1:0] qc_full;
        logic [T_W-1:0]         rs;
        logic [T_W-1:0]         rc;
        logic [T_W-1:0]         ts_new;
        logic [T_W-1:0]         tc_new;

        assign ps_full = (T_W+X_W)'(tb[j].ts) * (T_W+X_W)'(tb[j].x2)
                         + (T_W+X_W)'(ONE_Q30 >> 1);
        assign pc_full = (T_W+X_W)'(tb[j].tc) * (T_W+X_W)'(tb[j].x2)
                         + (T_W+X_W)'(ONE_Q30 >> 1);
        assign qs_full = (T_W+RECIP_W)'(m_ps_reg) * (T_W+RECIP_W)'(SIN_RECIP[j]);
        assign qc_full = (T_W+RECIP_W)'(m_pc_reg) * (T_W+RECIP_W)'(COS_RECIP[j]);

        always_comb
        begin
            rs     = r_ps_reg - r_qs_reg * T_W'(SIN_DIV[j]);
            rc     = r_pc_reg - r_qc_reg * T_W'(COS_DIV[j]);
            ts_new = r_qs_reg + T_W'(rs >= T_W'(SIN_DIV[j]));
            tc_new = r_qc_reg + T_W'(rc >= T_W'(COS_DIV[j]));
            s_next = r_reg;
            s_next.tc = tc_new;
            s_next.cs = (j % 2 == 0) ? r_reg.cs - tc_new : r_reg.cs + tc_new;
            if (j < SIN_TERMS)
            begin
                s_next.ts = ts_new;
                s_next.sn = (j % 2 == 0) ? r_reg.sn - ts_new : r_reg.sn + ts_new;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                m_reg <= '0;
                r_reg <= '0;
                s_reg <= '0;
            end
            else if (en)
            begin
                m_reg <= tb[j];
                r_reg <= m_reg;
                s_reg <= s_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_ps_reg <= ps_full[T_W+X_W-1:X_W];
                m_pc_reg <= pc_full[T_W+X_W-1:X_W];
                r_ps_reg <= m_ps_reg;
                r_pc_reg <= m_pc_reg;
                r_qs_reg <= qs_full[T_W+RECIP_W-1:RECIP_W];
                r_qc_reg <= qc_full[T_W+RECIP_W-1:RECIP_W];
            end
        end

        assign tb[j+1] = s_reg;
    end

    // stage F: round to output format, undo octant and quadrant fold
    ctl_t  f_ctl_reg;
    trig_t f_sin_reg;
    trig_t f_cos_reg;
    trig_t f_sin_next;
    trig_t f_cos_next;
    trm_t  fin;
    logic [T_W-1:0] sn_rnd;
    logic [T_W-1:0] cs_rnd;
    trig_t sv;
    trig_t cv;

    assign fin = tb[NUM_TERMS];

    always_comb
    begin
        sn_rnd = fin.sn + (T_W'(1) << (RND_SH - 1));
        cs_rnd = fin.cs + (T_W'(1) << (RND_SH - 1));
        if (fin.swap)
        begin
            sv = trig_t'({1'b0, cs_rnd[T_W-1:RND_SH]});
            cv = trig_t'({1'b0, sn_rnd[T_W-1:RND_SH]});
        end
        else
        begin
            sv = trig_t'({1'b0, sn_rnd[T_W-1:RND_SH]});
            cv = trig_t'({1'b0, cs_rnd[T_W-1:RND_SH]});
        end
        case (fin.q)
            2'd0:
            begin
                f_sin_next = sv;
                f_cos_next = cv;
            end
            2'd1:
            begin
                f_sin_next = cv;
                f_cos_next = -sv;
            end
            2'd2:
            begin
                f_sin_next = -sv;
                f_cos_next = -cv;
            end
            default:
            begin
                f_sin_next = -cv;
                f_cos_next = sv;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_ctl_reg <= '0;
        else if (en)
            f_ctl_reg <= fin.ctl;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_sin_reg <= f_sin_next;
            f_cos_reg <= f_cos_next;
        end
    end

    assign ctl_out = f_ctl_reg;
    assign sin_val = f_sin_reg;
    assign cos_val = f_cos_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ncr_rotate.sv
// Pipelined matrix build and matrix-vector product with rounding and saturation
`default_nettype none

module ncr_rotate
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire ncr_pkg::ctl_t  ctl_in,
    input  wire ncr_pkg::trig_t st,
    input  wire ncr_pkg::trig_t ct,
    input  wire ncr_pkg::trig_t sp,
    input  wire ncr_pkg::trig_t cp,
    input  wire ncr_pkg::vec3_t vec,
    output ncr_pkg::ctl_t       ctl_out,
    output ncr_pkg::vec_t       x,
    output ncr_pkg::vec_t       y,
    output ncr_pkg::vec_t       z
);
    import ncr_pkg::*;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ROW_W-1:0]  row_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    function automatic trig_t rnd_prod(input prod_t v);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] m;
        begin
            mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
            m   = (mag + (PROD_W'(1) << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
            rnd_prod = v[PROD_W-1] ? -trig_t'(m) : trig_t'(m);
        end
    endfunction

    // stage 1: trig products
    ctl_t  p1_ctl_reg;
    prod_t p1_ctcp_reg, p1_ctsp_reg, p1_stcp_reg, p1_stsp_reg;
    trig_t p1_st_reg, p1_ct_reg, p1_sp_reg, p1_cp_reg;
    vec3_t p1_vec_reg;

    // stage 2: rounded matrix entries
    ctl_t  p2_ctl_reg;
    trig_t p2_ctcp_reg, p2_ctsp_reg, p2_stcp_reg, p2_stsp_reg;
    trig_t p2_st_reg, p2_ct_reg, p2_sp_reg, p2_cp_reg;
    vec3_t p2_vec_reg;

    // stage 3: row products
    ctl_t p3_ctl_reg;
    row_t px0_reg, px1_reg, px2_reg, py0_reg, py1_reg, py2_reg, pz0_reg, pz1_reg;

    // stage 4: row sums
    ctl_t p4_ctl_reg;
    sum_t sx_reg, sy_reg, sz_reg;

    // stage 5: magnitude rounding
    ctl_t             p5_ctl_reg;
    logic [MAG_W-1:0] mx_reg, my_reg, mz_reg;
    logic             nx_reg, ny_reg, nz_reg;

    // stage 6: saturation
    ctl_t p6_ctl_reg;
    vec_t x_reg, y_reg, z_reg;

    function automatic logic [MAG_W-1:0] rnd_mag(input sum_t s);
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] m;
        begin
            mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
            m   = mag + (SUM_W'(1) << (TRIG_FRAC_BITS - 1));
            rnd_mag = m[SUM_W-1:TRIG_FRAC_BITS];
        end
    endfunction

    function automatic vec_t sat(input logic [MAG_W-1:0] m, input logic neg);
        logic signed [MAG_W:0] sv;
        begin
            sv = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
            if (!neg && m > MAG_W'(VEC_MAX))
                sat = vec_t'(VEC_MAX);
            else if (neg && m > MAG_W'(VEC_MAX + 1))
                sat = vec_t'(-VEC_MAX - 1);
            else
                sat = sv[VEC_WIDTH-1:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_ctl_reg <= '0;
            p2_ctl_reg <= '0;
            p3_ctl_reg <= '0;
            p4_ctl_reg <= '0;
            p5_ctl_reg <= '0;
            p6_ctl_reg <= '0;
        end
        else if (en)
        begin
            p1_ctl_reg <= ctl_in;
            p2_ctl_reg <= p1_ctl_reg;
            p3_ctl_reg <= p2_ctl_reg;
            p4_ctl_reg <= p3_ctl_reg;
            p5_ctl_reg <= p4_ctl_reg;
            p6_ctl_reg <= p5_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_ctcp_reg <= PROD_W'(ct) * PROD_W'(cp);
            p1_ctsp_reg <= PROD_W'(ct) * PROD_W'(sp);
            p1_stcp_reg <= PROD_W'(st) * PROD_W'(cp);
            p1_stsp_reg <= PROD_W'(st) * PROD_W'(sp);
            p1_st_reg   <= st;
            p1_ct_reg   <= ct;
            p1_sp_reg   <= sp;
            p1_cp_reg   <= cp;
            p1_vec_reg  <= vec;

            p2_ctcp_reg <= rnd_prod(p1_ctcp_reg);
            p2_ctsp_reg <= rnd_prod(p1_ctsp_reg);
            p2_stcp_reg <= rnd_prod(p1_stcp_reg);
            p2_stsp_reg <= rnd_prod(p1_stsp_reg);
            p2_st_reg   <= p1_st_reg;
            p2_ct_reg   <= p1_ct_reg;
            p2_sp_reg   <= p1_sp_reg;
            p2_cp_reg   <= p1_cp_reg;
            p2_vec_reg  <= p1_vec_reg;

            px0_reg <= ROW_W'(p2_ctcp_reg) * ROW_W'(p2_vec_reg.n);
            px1_reg <= ROW_W'(p2_sp_reg)   * ROW_W'(p2_vec_reg.e);
            px2_reg <= ROW_W'(p2_stcp_reg) * ROW_W'(p2_vec_reg.d);
            py0_reg <= ROW_W'(p2_ctsp_reg) * ROW_W'(p2_vec_reg.n);
            py1_reg <= ROW_W'(p2_cp_reg)   * ROW_W'(p2_vec_reg.e);
            py2_reg <= ROW_W'(p2_stsp_reg) * ROW_W'(p2_vec_reg.d);
            pz0_reg <= ROW_W'(p2_st_reg)   * ROW_W'(p2_vec_reg.n);
            pz1_reg <= ROW_W'(p2_ct_reg)   * ROW_W'(p2_vec_reg.d);

            // rows of [-ct*cp -sp -st*cp; -ct*sp cp -st*sp; st 0 -ct]
            sx_reg <= -SUM_W'(px0_reg) - SUM_W'(px1_reg) - SUM_W'(px2_reg);
            sy_reg <= -SUM_W'(py0_reg) + SUM_W'(py1_reg) - SUM_W'(py2_reg);
            sz_reg <= SUM_W'(pz0_reg) - SUM_W'(pz1_reg);

            mx_reg <= rnd_mag(sx_reg);
            my_reg <= rnd_mag(sy_reg);
            mz_reg <= rnd_mag(sz_reg);
            nx_reg <= sx_reg[SUM_W-1];
            ny_reg <= sy_reg[SUM_W-1];
            nz_reg <= sz_reg[SUM_W-1];

            // pole: outputs forced to zero
            x_reg <= p5_ctl_reg.pole ? '0 : sat(mx_reg, nx_reg);
            y_reg <= p5_ctl_reg.pole ? '0 : sat(my_reg, ny_reg);
            z_reg <= p5_ctl_reg.pole ? '0 : sat(mz_reg, nz_reg);
        end
    end

    assign ctl_out = p6_ctl_reg;
    assign x       = x_reg;
    assign y       = y_reg;
    assign z       = z_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ned_to_ecef_vector_rotation_top.sv
// Top level: NED vector rotated into Earth-fixed x, y, z at a given latitude/longitude
//
// Input channel: in_valid / in_stall with north_comp, east_comp, down_comp,
// latitude and longitude (1/256 degree). A transfer happens on a rising edge
// with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with ecef_x, ecef_y, ecef_z and
// pole_error. pole_error is set, with zero outputs, at latitude +/-90 degree.
// The path is one input register, 24 stages of sine/cosine (range fold,
// radian conversion, six series terms of multiply, reciprocal divide and
// correct), then 6 stages of matrix build, row products, rounding and
// saturation. One transfer per cycle is sustained while out_stall is low.
// The whole pipeline advances together; while a result waits under
// out_stall the pipeline holds and in_stall is raised, so nothing is lost
// or repeated. Empty stages keep their valid bit low.
// Reset clears every valid bit.
`default_nettype none

module ned_to_ecef_vector_rotation_top
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [ncr_pkg::VEC_WIDTH-1:0] north_comp,
    input  wire logic signed [ncr_pkg::VEC_WIDTH-1:0] east_comp,
    input  wire logic signed [ncr_pkg::VEC_WIDTH-1:0] down_comp,
    input  wire logic signed [ncr_pkg::LAT_W-1:0]     latitude,
    input  wire logic signed [ncr_pkg::LON_W-1:0]     longitude,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [ncr_pkg::VEC_WIDTH-1:0]      ecef_x,
    output logic signed [ncr_pkg::VEC_WIDTH-1:0]      ecef_y,
    output logic signed [ncr_pkg::VEC_WIDTH-1:0]      ecef_z,
    output logic                                     pole_error
);
    import ncr_pkg::*;

    logic  en;
    ctl_t  rot_ctl;
    vec_t  rot_x, rot_y, rot_z;

    assign en       = !(rot_ctl.valid && out_stall);
    assign in_stall = !en;

    // input stage: polar angle and wrapped azimuth
    logic signed [ANG_W:0] th;
    logic signed [ANG_W:0] lw;
    logic signed [ANG_W:0] ph;
    ang_t  th_next;
    ang_t  ph_next;
    logic  pole_next;

    always_comb
    begin
        th      = (ANG_W+1)'(ANG_QUARTER) - (ANG_W+1)'(latitude);
        th_next = (th < 0) ? ang_t'(th + (ANG_W+1)'(ANG_FULL)) : ang_t'(th);
        lw      = (ANG_W+1)'(longitude);
        ph      = (lw < 0) ? lw + (ANG_W+1)'(ANG_FULL) : lw;
        ph_next = ph[ANG_W-1:0];
        pole_next = (latitude == LAT_W'(ANG_QUARTER)) || (latitude == LAT_W'(-ANG_QUARTER));
    end

    ctl_t  s0_ctl_reg;
    ang_t  s0_th_reg;
    ang_t  s0_ph_reg;
    vec3_t s0_vec_reg;
    vec3_t vd_reg [SC_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_ctl_reg <= '0;
        else if (en)
        begin
            s0_ctl_reg.valid <= in_valid;
            s0_ctl_reg.pole  <= pole_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_th_reg    <= th_next;
            s0_ph_reg    <= ph_next;
            s0_vec_reg.n <= north_comp;
            s0_vec_reg.e <= east_comp;
            s0_vec_reg.d <= down_comp;
            vd_reg[0]    <= s0_vec_reg;
            for (int i = 1; i < SC_LAT; i++)
                vd_reg[i] <= vd_reg[i-1];
        end
    end

    ctl_t  sc_ctl;
    trig_t st, ct, sp, cp;

    ncr_sincos u_theta
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (s0_ctl_reg),
        .angle   (s0_th_reg),
        .ctl_out (sc_ctl),
        .sin_val (st),
        .cos_val (ct)
    );

    ncr_sincos u_phi
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (s0_ctl_reg),
        .angle   (s0_ph_reg),
        .ctl_out (),
        .sin_val (sp),
        .cos_val (cp)
    );

    ncr_rotate u_rotate
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (sc_ctl),
        .st      (st),
        .ct      (ct),
        .sp      (sp),
        .cp      (cp),
        .vec     (vd_reg[SC_LAT-1]),
        .ctl_out (rot_ctl),
        .x       (rot_x),
        .y       (rot_y),
        .z       (rot_z)
    );

    assign out_valid  = rot_ctl.valid;
    assign pole_error = rot_ctl.pole;
    assign ecef_x     = rot_x;
    assign ecef_y     = rot_y;
    assign ecef_z     = rot_z;

endmodule

`default_nettype wire

// File: hw/rtl/ncr_checker.sv
// Port-level checks for the rotation block, bound to the top level
`default_nettype none

module ncr_checker
(
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_stall,
    input wire logic                                out_valid,
    input wire logic                                out_stall,
    input wire logic signed [ncr_pkg::VEC_WIDTH-1:0] ecef_x,
    input wire logic signed [ncr_pkg::VEC_WIDTH-1:0] ecef_y,
    input wire logic signed [ncr_pkg::VEC_WIDTH-1:0] ecef_z,
    input wire logic                                pole_error
);

    // a waiting result holds until transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(ecef_x) && $stable(ecef_y)
            && $stable(ecef_z) && $stable(pole_error))
        else $error("result changed while stalled");

    // pole results carry zero components
    a_pole_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pole_error |-> ecef_x == '0 && ecef_y == '0 && ecef_z == '0)
        else $error("pole result not zero");

    // input only held back by a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // back-pressure released when the output moves; in_stall is low whenever out_stall is, so this holds vacuously
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall && !out_stall |=> !in_stall || out_valid)
        else $error("input stall not released");

endmodule

bind ned_to_ecef_vector_rotation_top ncr_checker u_ncr_checker (.*);

`default_nettype wire

// File: dv/tb_ned_to_ecef_vector_rotation_top.sv
// Self-checking testbench for the NED to ECEF vector rotation block
`timescale 1ns / 1ps

module tb_ned_to_ecef_vector_rotation_top;
    import ncr_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam int WATCHDOG_MAX = 4000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        vec_t                    n;
        vec_t                    e;
        vec_t                    d;
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
        bit                      typed;
    } vec_item_t;

    typedef struct {
        vec_t x;
        vec_t y;
        vec_t z;
        logic pole;
    } ecef_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    vec_t                    north_comp = '0;
    vec_t                    east_comp = '0;
    vec_t                    down_comp = '0;
    logic signed [LAT_W-1:0] latitude = '0;
    logic signed [LON_W-1:0] longitude = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    vec_t                    ecef_x;
    vec_t                    ecef_y;
    vec_t                    ecef_z;
    logic                    pole_error;

    vec_item_t vec_items[$];
    ecef_t     ecef_typed[$];
    ecef_t     ecef_pending[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    longint    cycle_count = 0;

    ned_to_ecef_vector_rotation_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .north_comp (north_comp),
        .east_comp  (east_comp),
        .down_comp  (down_comp),
        .latitude   (latitude),
        .longitude  (longitude),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ecef_x     (ecef_x),
        .ecef_y     (ecef_y),
        .ecef_z     (ecef_z),
        .pole_error (pole_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint mul_q30(longint a, longint b);
        logic [63:0] p;
        p = a * b;
        p = p + (64'd1 << 29);
        return longint'(p >> 30);
    endfunction

    function automatic longint round_shift(longint v, int sh);
        logic [63:0] m;
        m = (v < 0) ? -v : v;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // sine/cosine of an angle in 1/256 degree, Q(TRIG_FRAC_BITS)
    function automatic void angle_sin_cos(input longint a, output longint s, output longint c);
        longint q, r, x, x2, t, sn, cs, tmp;
        bit     swap;
        logic [63:0] xw;
        a = a % ANG_FULL;
        if (a < 0)
            a = a + ANG_FULL;
        q = a / ANG_QUARTER;
        r = a % ANG_QUARTER;
        swap = r > ANG_EIGHTH;
        if (swap)
            r = ANG_QUARTER - r;
        xw = (64'(r) * 64'd3373259426 + 64'd23040) / 64'd46080;
        x = longint'(xw);
        x2 = mul_q30(x, x);
        t = x;
        sn = x;
        for (int k = 1; k <= 5; k++)
        begin
            t = mul_q30(t, x2) / ((2 * k) * (2 * k + 1));
            sn = (k & 1) ? sn - t : sn + t;
        end
        t = longint'(1) << 30;
        cs = t;
        for (int k = 1; k <= 6; k++)
        begin
            t = mul_q30(t, x2) / ((2 * k - 1) * (2 * k));
            cs = (k & 1) ? cs - t : cs + t;
        end
        if (swap)
        begin
            tmp = sn;
            sn = cs;
            cs = tmp;
        end
        sn = round_shift(sn, 30 - TRIG_FRAC_BITS);
        cs = round_shift(cs, 30 - TRIG_FRAC_BITS);
        case (q)
            0: begin s = sn;  c = cs;  end
            1: begin s = cs;  c = -sn; end
            2: begin s = -sn; c = -cs; end
            default: begin s = -cs; c = sn; end
        endcase
    endfunction

    function automatic vec_t row_sum(longint m0, longint m1, longint m2,
                                     longint n, longint e, longint d);
        longint v;
        v = round_shift(m0 * n + m1 * e + m2 * d, TRIG_FRAC_BITS);
        if (v > VEC_MAX)
            v = VEC_MAX;
        if (v < -VEC_MAX - 1)
            v = -VEC_MAX - 1;
        return vec_t'(v);
    endfunction

    function automatic ecef_t rotate_to_ecef(vec_item_t it);
        ecef_t  r;
        longint n, e, d, lat, lon, st, ct, sp, cp, ctcp, ctsp, stcp, stsp;
        n = longint'(it.n);
        e = longint'(it.e);
        d = longint'(it.d);
        lat = longint'(it.lat);
        lon = longint'(it.lon);
        if (lat == ANG_QUARTER || lat == -ANG_QUARTER)
        begin
            r = '{x: '0, y: '0, z: '0, pole: 1'b1};
            return r;
        end
        if (lon < 0)
            lon = lon + ANG_FULL;
        angle_sin_cos(ANG_QUARTER - lat, st, ct);
        angle_sin_cos(lon, sp, cp);
        ctcp = round_shift(ct * cp, TRIG_FRAC_BITS);
        ctsp = round_shift(ct * sp, TRIG_FRAC_BITS);
        stcp = round_shift(st * cp, TRIG_FRAC_BITS);
        stsp = round_shift(st * sp, TRIG_FRAC_BITS);
        r.x = row_sum(-ctcp, -sp, -stcp, n, e, d);
        r.y = row_sum(-ctsp, cp, -stsp, n, e, d);
        r.z = row_sum(st, 0, -ct, n, e, d);
        r.pole = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %0s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        mismatches++;
    endtask

    task automatic add_item(int n, int e, int d, int lat, int lon, bit typed,
                            ecef_t want);
        vec_item_t it;
        it = '{n: vec_t'(n), e: vec_t'(e), d: vec_t'(d), lat: LAT_W'(lat),
               lon: LON_W'(lon), typed: typed};
        vec_items.push_back(it);
        if (typed)
            ecef_typed.push_back(want);
    endtask

    task automatic build_stimulus();
        ecef_t z, p;
        int    sel;
        z = '{x: '0, y: '0, z: '0, pole: 1'b0};
        p = '{x: '0, y: '0, z: '0, pole: 1'b1};
        // directed table: typed rows where the answer is plain, then edge rows checked by rotate_to_ecef
        add_item(0, 0, 0, 0, 0, 1, z);
        add_item(0, 0, 0, 12345, -777, 1, z);
        add_item(32767, -32768, 32767, 23040, 0, 1, p);
        add_item(-32768, -32768, -32768, -23040, 46080, 1, p);
        add_item(1000, -2000, 3000, 23040, -46079, 1, p);
        add_item(32767, 32767, 32767, 0, 0, 0, z);
        add_item(-32768, -32768, -32768, 0, 0, 0, z);
        add_item(32767, -32768, 32767, 11520, 11520, 0, z);
        add_item(-32768, 32767, -32768, -11520, -11520, 0, z);
        add_item(12000, -5000, 7000, 23039, 46080, 0, z);
        add_item(12000, -5000, 7000, -23039, -46079, 0, z);
        add_item(32767, 32767, 32767, 32767, 65535, 0, z);
        add_item(-32768, -32768, -32768, -32768, -65536, 0, z);
        add_item(20000, 20000, 20000, 23041, 1, 0, z);
        add_item(-20000, 20000, -20000, -23041, -1, 0, z);
        add_item(32767, 0, 0, 5760, 23040, 0, z);
        add_item(0, 32767, 0, -5760, -23040, 0, z);
        add_item(0, 0, 32767, 17280, 69120 - 92160, 0, z);
        add_item(1, 1, 1, 11521, 11519, 0, z);
        add_item(-1, -1, -1, -11519, 34561, 0, z);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 8)
                add_item($urandom, $urandom, $urandom,
                         ($urandom_range(1) != 0) ? 23040 : -23040, $urandom, 0, z);
            else if (sel < 70)
                add_item($urandom, $urandom, $urandom, $urandom_range(46080) - 23040,
                         $urandom_range(92159) - 46079, 0, z);
            else if (sel < 80)
                add_item(($urandom_range(1) != 0) ? 32767 : -32768,
                         ($urandom_range(1) != 0) ? 32767 : -32768,
                         ($urandom_range(1) != 0) ? 32767 : -32768,
                         $urandom_range(46080) - 23040, $urandom_range(92159) - 46079, 0, z);
            else
                add_item($urandom, $urandom, $urandom, $urandom, $urandom, 0, z);
        end
    endtask

    // output side: stall at random, quiet stretch in the middle
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 700 && cycle_count < 1000)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 12);
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        ecef_t want;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (ecef_pending.size() == 0)
                report_mismatch("unexpected result, pole_error", pole_error, 0);
            else
            begin
                want = ecef_pending.pop_front();
                if (ecef_x !== want.x)
                    report_mismatch("ecef_x", ecef_x, want.x);
                if (ecef_y !== want.y)
                    report_mismatch("ecef_y", ecef_y, want.y);
                if (ecef_z !== want.z)
                    report_mismatch("ecef_z", ecef_z, want.z);
                if (pole_error !== want.pole)
                    report_mismatch("pole_error", pole_error, want.pole);
            end
        end
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        vec_item_t cur;
        int        idx;
        build_stimulus();
        idx = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (idx < vec_items.size() || in_valid)
        begin
            @(posedge clk);
            if (in_valid && !in_stall)
            begin
                if (cur.typed)
                    ecef_pending.push_back(ecef_typed.pop_front());
                else
                    ecef_pending.push_back(rotate_to_ecef(cur));
                idx++;
            end
            if (in_valid && in_stall)
                ;
            else if (idx < vec_items.size() &&
                     ((idx > 500 && idx < 800) || $urandom_range(99) >= 12))
            begin
                cur = vec_items[idx];
                north_comp <= cur.n;
                east_comp <= cur.e;
                down_comp <= cur.d;
                latitude <= cur.lat;
                longitude <= cur.lon;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        while (ecef_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: ned_to_ecef_vector_rotation_top.f
hw/rtl/ncr_pkg.sv
hw/rtl/ncr_sincos.sv
hw/rtl/ncr_rotate.sv
hw/rtl/ned_to_ecef_vector_rotation_top.sv
hw/rtl/ncr_checker.sv
dv/tb_ned_to_ecef_vector_rotation_top.sv
